/* rtl/tpqe_pkg.sv */
// ---------------------------------------------------------------------------
// tpqe_pkg: shared definitions of the thick polyline quad expander
// Constants, register indexes and the request bundle for the iterative unit.
// ---------------------------------------------------------------------------
`default_nettype none

package tpqe_pkg;

  localparam int COORD_BITS_DEF = 32;
  localparam int MAG_W          = 33;   // magnitude of a coordinate difference
  localparam int AXIS_W         = 31;   // magnitude after the overflow shift
  localparam int LEN_W          = 32;   // integer square root result
  localparam int UNIT_W         = 17;   // Q16 unit vector component, at most 2^16
  localparam int FRAC_BITS      = 16;
  localparam int HALF_SHIFT     = 17;
  localparam int WORK_W         = 64;
  localparam int SQRT_STEPS     = 32;
  localparam int DIV_STEPS      = 17;
  localparam int CNT_W          = 6;
  localparam int VTX_W          = 16;

  localparam logic [7:0] THIN_LIMIT = 8'd5;

  localparam logic REG_CENTER_X = 1'b0;
  localparam logic REG_CENTER_Y = 1'b1;

  typedef struct packed {
    logic                start;
    logic                is_div;
    logic [WORK_W-1:0]   acc;
    logic [WORK_W-1:0]   d;
  } unit_req_t;

endpackage

`default_nettype wire

/* rtl/tpqe_sqdiv.sv */
// ---------------------------------------------------------------------------
// tpqe_sqdiv: shared iterative square root and divider
// One compare-and-subtract per cycle, used for isqrt and restoring division.
// ---------------------------------------------------------------------------
`default_nettype none

module tpqe_sqdiv (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire tpqe_pkg::unit_req_t         req,
  output logic                             done,
  output logic [tpqe_pkg::WORK_W-1:0]      result
);

  logic [tpqe_pkg::WORK_W-1:0] acc_r, acc_nxt;
  logic [tpqe_pkg::WORK_W-1:0] res_r, res_nxt;
  logic [tpqe_pkg::WORK_W-1:0] d_r, d_nxt;
  logic [tpqe_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                        busy_r, busy_nxt;
  logic                        div_r, div_nxt;
  logic                        done_r, done_nxt;
  logic [tpqe_pkg::WORK_W-1:0] sub_op;
  logic                        ge;

  // In square root mode the trial value is res + bit, in division the divisor.
  assign sub_op = div_r ? d_r : (res_r + d_r);
  assign ge     = (acc_r >= sub_op);

  always_comb begin
    acc_nxt  = acc_r;
    res_nxt  = res_r;
    d_nxt    = d_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    div_nxt  = div_r;
    done_nxt = 1'b0;
    if (req.start) begin
      acc_nxt  = req.acc;
      res_nxt  = '0;
      d_nxt    = req.d;
      div_nxt  = req.is_div;
      cnt_nxt  = req.is_div ? tpqe_pkg::CNT_W'(tpqe_pkg::DIV_STEPS)
                            : tpqe_pkg::CNT_W'(tpqe_pkg::SQRT_STEPS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (ge) begin
        acc_nxt = acc_r - sub_op;
      end
      if (div_r) begin
        res_nxt = {res_r[tpqe_pkg::WORK_W-2:0], ge};
        d_nxt   = d_r >> 1;
      end else begin
        res_nxt = (res_r >> 1) + (ge ? d_r : '0);
        d_nxt   = d_r >> 2;
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == tpqe_pkg::CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    res_r <= res_nxt;
    d_r   <= d_nxt;
    cnt_r <= cnt_nxt;
    div_r <= div_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done   = done_r;
  assign result = res_r;

endmodule

`default_nettype wire

/* rtl/thick_polyline_quad_expander_unit.sv */
// ---------------------------------------------------------------------------
// thick_polyline_quad_expander_unit: polyline to thick quad vertex expander
// Turns polyline points into thin-strip vertices or four-vertex quads.
// ---------------------------------------------------------------------------
// A point with a width below 5 produces one vertex, the point relative to
// the map center. A thick point that continues a polyline produces four
// vertices of a quad around the segment from the previous point. The block
// works on one transaction at a time: in_ready is high only while idle. A
// thin point is held until its one vertex is taken. A thick segment first
// uses the shared iterative unit for the square root and then each of the
// two divisions, and then offers its four output transactions. A thick
// point that starts a line produces no vertex and never leaves idle.
`default_nettype none

module thick_polyline_quad_expander_unit #(
  parameter int COORD_BITS = tpqe_pkg::COORD_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // Configuration port.
  input  wire logic               cfg_we,
  input  wire logic               cfg_index,
  input  wire logic [31:0]        cfg_data,
  // Input channel.
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [31:0] in_point_x,
  input  wire logic signed [31:0] in_point_y,
  input  wire logic [7:0]         in_line_width,
  input  wire logic               in_first_point,
  // Result channel.
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [15:0]      out_vertex_x,
  output logic signed [15:0]      out_vertex_y,
  output logic                    out_last_vertex
);

  localparam int MW = tpqe_pkg::MAG_W;
  localparam int AW = tpqe_pkg::AXIS_W;
  localparam int VW = tpqe_pkg::VTX_W;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DIFF    = 4'd1;
  localparam logic [3:0] S_MUL_X   = 4'd2;
  localparam logic [3:0] S_MUL_Y   = 4'd3;
  localparam logic [3:0] S_SUM     = 4'd4;
  localparam logic [3:0] S_SQRT_GO = 4'd5;
  localparam logic [3:0] S_SQRT_WT = 4'd6;
  localparam logic [3:0] S_DIVX_GO = 4'd7;
  localparam logic [3:0] S_DIVX_WT = 4'd8;
  localparam logic [3:0] S_DIVY_GO = 4'd9;
  localparam logic [3:0] S_DIVY_WT = 4'd10;
  localparam logic [3:0] S_OFFS    = 4'd11;
  localparam logic [3:0] S_EMIT    = 4'd12;

  logic [3:0]                 state_r, state_nxt;
  logic [31:0]                center_x_r, center_y_r;
  logic [COORD_BITS-1:0]      cur_x_r, cur_y_r, prev_x_r, prev_y_r;
  logic                       have_prev_r, have_prev_nxt;
  logic [7:0]                 width_r;
  logic                       thin_r;
  logic [AW-1:0]              ax_r, ay_r;
  logic                       dx_pos_r, dx_neg_r, dy_pos_r, dy_neg_r;
  logic [2*AW-1:0]            mul_r;
  logic [2*AW:0]              sum_r;
  logic [tpqe_pkg::LEN_W-1:0] len_r;
  logic [tpqe_pkg::UNIT_W-1:0] ux_r, uy_r;
  logic [VW-1:0]              px_r, py_r;
  logic [1:0]                 k_r;

  // Coordinate differences are formed on sign-extended MAG_W-bit values.
  logic signed [MW-1:0]       dx, dy;
  logic [MW-1:0]              ax_full, ay_full;
  logic                       big;
  logic [AW-1:0]              mul_op;
  logic [7:0]                 mx, my;
  logic [24:0]                wx, wy;

  tpqe_pkg::unit_req_t        req;
  logic                       unit_done;
  logic [tpqe_pkg::WORK_W-1:0] unit_res;

  assign dx = $signed({{(MW-COORD_BITS){cur_x_r[COORD_BITS-1]}}, cur_x_r})
            - $signed({{(MW-COORD_BITS){prev_x_r[COORD_BITS-1]}}, prev_x_r});
  assign dy = $signed({{(MW-COORD_BITS){cur_y_r[COORD_BITS-1]}}, cur_y_r})
            - $signed({{(MW-COORD_BITS){prev_y_r[COORD_BITS-1]}}, prev_y_r});
  assign ax_full = dx[MW-1] ? MW'(-dx) : MW'(dx);
  assign ay_full = dy[MW-1] ? MW'(-dy) : MW'(dy);
  // A magnitude of 2^31 or more halves both axes so the squares fit 63 bits.
  assign big     = (ax_full[MW-1:AW] != '0) || (ay_full[MW-1:AW] != '0);

  assign mul_op = (state_r == S_MUL_X) ? ax_r : ay_r;

  // Offset magnitudes: width times the Q16 unit component, halved.
  assign wx = 25'(width_r) * 25'(ux_r);
  assign wy = 25'(width_r) * 25'(uy_r);
  assign mx = wx[tpqe_pkg::HALF_SHIFT +: 8];
  assign my = wy[tpqe_pkg::HALF_SHIFT +: 8];

  // Requests to the shared unit: square root of the sum of squares, then the
  // two Q16 divisions by the segment length.
  always_comb begin
    req        = '0;
    req.is_div = 1'b1;
    req.d      = {16'b0, len_r, 16'b0};
    unique case (state_r)
      S_SQRT_GO: begin
        req.start  = 1'b1;
        req.is_div = 1'b0;
        req.acc    = tpqe_pkg::WORK_W'(sum_r);
        req.d      = tpqe_pkg::WORK_W'(1) << 62;
      end
      S_DIVX_GO: begin
        req.start = 1'b1;
        req.acc   = tpqe_pkg::WORK_W'({ax_r, 16'b0});
      end
      S_DIVY_GO: begin
        req.start = 1'b1;
        req.acc   = tpqe_pkg::WORK_W'({ay_r, 16'b0});
      end
      default: begin
        req.start = 1'b0;
      end
    endcase
  end

  tpqe_sqdiv u_sqdiv (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (req),
    .done   (unit_done),
    .result (unit_res)
  );

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    have_prev_nxt = have_prev_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_line_width < tpqe_pkg::THIN_LIMIT) begin
            state_nxt = S_EMIT;
          end else if (!in_first_point && have_prev_r) begin
            state_nxt = S_DIFF;
          end else begin
            have_prev_nxt = 1'b1;
          end
        end
      end
      S_DIFF:    state_nxt = S_MUL_X;
      S_MUL_X:   state_nxt = S_MUL_Y;
      S_MUL_Y:   state_nxt = S_SUM;
      S_SUM:     state_nxt = S_SQRT_GO;
      S_SQRT_GO: state_nxt = S_SQRT_WT;
      S_SQRT_WT: begin
        if (unit_done) begin
          state_nxt = (unit_res[tpqe_pkg::LEN_W-1:0] == '0) ? S_EMIT : S_DIVX_GO;
        end
      end
      S_DIVX_GO: state_nxt = S_DIVX_WT;
      S_DIVX_WT: if (unit_done) state_nxt = S_DIVY_GO;
      S_DIVY_GO: state_nxt = S_DIVY_WT;
      S_DIVY_WT: if (unit_done) state_nxt = S_OFFS;
      S_OFFS:    state_nxt = S_EMIT;
      S_EMIT: begin
        if (out_ready && out_last_vertex) begin
          state_nxt     = S_IDLE;
          have_prev_nxt = 1'b1;
        end
      end
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      have_prev_r <= 1'b0;
      center_x_r  <= '0;
      center_y_r  <= '0;
      prev_x_r    <= '0;
      prev_y_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      have_prev_r <= have_prev_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          tpqe_pkg::REG_CENTER_X: center_x_r <= cfg_data;
          tpqe_pkg::REG_CENTER_Y: center_y_r <= cfg_data;
          default: ;
        endcase
      end
      // A point that yields no vertex becomes the previous point at once;
      // otherwise the swap happens when its last vertex leaves.
      if (state_r == S_IDLE && in_valid && state_nxt == S_IDLE) begin
        prev_x_r <= in_point_x[COORD_BITS-1:0];
        prev_y_r <= in_point_y[COORD_BITS-1:0];
      end else if (state_r == S_EMIT && out_ready && out_last_vertex) begin
        prev_x_r <= cur_x_r;
        prev_y_r <= cur_y_r;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      cur_x_r <= in_point_x[COORD_BITS-1:0];
      cur_y_r <= in_point_y[COORD_BITS-1:0];
      width_r <= in_line_width;
      thin_r  <= (in_line_width < tpqe_pkg::THIN_LIMIT);
      k_r     <= '0;
      px_r    <= '0;
      py_r    <= '0;
    end
    if (state_r == S_DIFF) begin
      ax_r     <= big ? ax_full[AW:1] : ax_full[AW-1:0];
      ay_r     <= big ? ay_full[AW:1] : ay_full[AW-1:0];
      dx_pos_r <= !dx[MW-1] && (dx != '0);
      dx_neg_r <= dx[MW-1];
      dy_pos_r <= !dy[MW-1] && (dy != '0);
      dy_neg_r <= dy[MW-1];
    end
    mul_r <= (2*AW)'(mul_op) * (2*AW)'(mul_op);
    if (state_r == S_MUL_Y) begin
      sum_r <= {1'b0, mul_r};
    end
    if (state_r == S_SUM) begin
      sum_r <= sum_r + {1'b0, mul_r};
    end
    if (state_r == S_SQRT_WT && unit_done) begin
      len_r <= unit_res[tpqe_pkg::LEN_W-1:0];
    end
    if (state_r == S_DIVX_WT && unit_done) begin
      ux_r <= unit_res[tpqe_pkg::UNIT_W-1:0];
    end
    if (state_r == S_DIVY_WT && unit_done) begin
      uy_r <= unit_res[tpqe_pkg::UNIT_W-1:0];
    end
    if (state_r == S_OFFS) begin
      // The offset is perpendicular: px follows -dy, py follows dx.
      px_r <= dy_pos_r ? -VW'(my) : (dy_neg_r ? VW'(my) : '0);
      py_r <= dx_pos_r ? VW'(mx) : (dx_neg_r ? -VW'(mx) : '0);
    end
    if (state_r == S_EMIT && out_ready) begin
      k_r <= k_r + 1'b1;
    end
  end

  // Vertex order of a quad: previous - offset, previous + offset,
  // current - offset, current + offset. A thin point is the current point.
  logic          use_cur, neg_off;
  logic [VW-1:0] base_x, base_y, off_x, off_y;

  assign use_cur = thin_r || k_r[1];
  assign neg_off = !k_r[0];
  assign base_x  = use_cur ? cur_x_r[VW-1:0] : prev_x_r[VW-1:0];
  assign base_y  = use_cur ? cur_y_r[VW-1:0] : prev_y_r[VW-1:0];
  assign off_x   = thin_r ? '0 : (neg_off ? -px_r : px_r);
  assign off_y   = thin_r ? '0 : (neg_off ? -py_r : py_r);

  assign in_ready        = (state_r == S_IDLE);
  assign out_valid       = (state_r == S_EMIT);
  assign out_vertex_x    = base_x + off_x - center_x_r[VW-1:0];
  assign out_vertex_y    = base_y + off_y - center_y_r[VW-1:0];
  assign out_last_vertex = thin_r || (k_r == 2'd3);

  // The block never takes a new transaction while a vertex is offered.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid)
    else $error("input accepted while a vertex is pending");

  // Delivering the last vertex returns the block to idle.
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last_vertex) |=> in_ready)
    else $error("block not idle after last vertex");

  // A thin point produces exactly one vertex, marked last.
  a_thin_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && thin_r) |-> out_last_vertex)
    else $error("thin point vertex not marked last");

  // A quad is offered only from the offset state, or from the square root wait for a zero-length segment.
  a_emit_order: assert property (@(posedge clk) disable iff (!rst_n)
    ($rose(out_valid) && !thin_r) |->
      ($past(state_r) == S_OFFS || $past(state_r) == S_SQRT_WT))
    else $error("quad emitted before offset was ready");

endmodule

`default_nettype wire

/* verif/thick_polyline_quad_expander_unit_tb.sv */
// ---------------------------------------------------------------------------
// thick_polyline_quad_expander_unit_tb: self-checking bench for the expander
// Sends directed and random polyline points, predicts every emitted vertex
// with a fixed-point model of the offset math and checks each output
// transaction in order, under several idle patterns on both channels.
// ---------------------------------------------------------------------------
`default_nettype none

module thick_polyline_quad_expander_unit_tb;

  typedef struct packed {
    logic [15:0] vx;
    logic [15:0] vy;
    logic        last;
  } vertex_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_index;
  logic [31:0] cfg_data;
  logic in_valid;
  logic in_ready;
  logic signed [31:0] in_point_x;
  logic signed [31:0] in_point_y;
  logic [7:0] in_line_width;
  logic in_first_point;
  logic out_valid;
  logic out_ready;
  logic signed [15:0] out_vertex_x;
  logic signed [15:0] out_vertex_y;
  logic out_last_vertex;

  thick_polyline_quad_expander_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_point_x(in_point_x), .in_point_y(in_point_y),
    .in_line_width(in_line_width), .in_first_point(in_first_point),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_vertex_x(out_vertex_x), .out_vertex_y(out_vertex_y),
    .out_last_vertex(out_last_vertex)
  );

  // Predictor state: our own copy of the center registers and the stored point.
  logic [31:0] ctr_x, ctr_y;
  logic signed [63:0] prev_x, prev_y;
  logic have_prev;
  vertex_t pending_vertices[$];

  int send_idle_pct;
  int recv_idle_pct;
  bit failed = 1'b0;
  longint cycle_count = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // The limit is many times what a full run needs, even under the heaviest stalls.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("** thick_polyline_quad_expander_unit: FAILED **");
      $finish;
    end
  end

  // The receiver stalls at random; ready is redrawn every cycle.
  always @(posedge clk) begin
    if (!rst_n)
      out_ready <= 1'b0;
    else
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Each output transaction is compared with the oldest predicted vertex.
  always @(posedge clk) begin
    vertex_t exp_v;
    if (rst_n && out_valid && out_ready) begin
      if (pending_vertices.size() == 0) begin
        $display("%0t: unexpected vertex x=%h y=%h last=%b", $time,
                 out_vertex_x, out_vertex_y, out_last_vertex);
        failed = 1'b1;
      end else begin
        exp_v = pending_vertices.pop_front();
        if (out_vertex_x !== exp_v.vx) begin
          $display("%0t: vertex_x expected %h actual %h", $time, exp_v.vx, out_vertex_x);
          failed = 1'b1;
        end
        if (out_vertex_y !== exp_v.vy) begin
          $display("%0t: vertex_y expected %h actual %h", $time, exp_v.vy, out_vertex_y);
          failed = 1'b1;
        end
        if (out_last_vertex !== exp_v.last) begin
          $display("%0t: last_vertex expected %b actual %b", $time,
                   exp_v.last, out_last_vertex);
          failed = 1'b1;
        end
      end
    end
  end

  function automatic logic [63:0] int_sqrt(logic [63:0] n);
    logic [63:0] res;
    logic [63:0] bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic vertex_t make_vertex(logic signed [63:0] x, logic signed [63:0] y,
                                          logic signed [63:0] ox, logic signed [63:0] oy,
                                          logic last);
    vertex_t v;
    logic [63:0] sx, sy;
    sx = x + ox - {32'd0, ctr_x};
    sy = y + oy - {32'd0, ctr_y};
    v.vx = sx[15:0];
    v.vy = sy[15:0];
    v.last = last;
    return v;
  endfunction

  // Works out the vertices that one accepted point causes and updates state.
  task automatic predict_vertices(logic [31:0] px_in, logic [31:0] py_in,
                                  logic [7:0] width, logic first);
    logic signed [63:0] cx, cy, dx, dy, ofs_x, ofs_y, mx, my;
    logic [63:0] ax, ay, len, ux, uy;
    cx = $signed(px_in);
    cy = $signed(py_in);
    if (width < tpqe_pkg::THIN_LIMIT) begin
      pending_vertices.push_back(make_vertex(cx, cy, 0, 0, 1'b1));
    end else if (!first && have_prev) begin
      dx = cx - prev_x;
      dy = cy - prev_y;
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      ofs_x = 0;
      ofs_y = 0;
      // Very long segments are halved so that the squared length fits.
      if (ax >= (64'd1 << 31) || ay >= (64'd1 << 31)) begin
        ax = ax >> 1;
        ay = ay >> 1;
      end
      len = int_sqrt(ax * ax + ay * ay);
      if (len != 0) begin
        ux = (ax << 16) / len;
        uy = (ay << 16) / len;
        mx = ({56'd0, width} * ux) >> tpqe_pkg::HALF_SHIFT;
        my = ({56'd0, width} * uy) >> tpqe_pkg::HALF_SHIFT;
        ofs_x = (dy > 0) ? -my : ((dy < 0) ? my : 0);
        ofs_y = (dx > 0) ? mx : ((dx < 0) ? -mx : 0);
      end
      pending_vertices.push_back(make_vertex(prev_x, prev_y, -ofs_x, -ofs_y, 1'b0));
      pending_vertices.push_back(make_vertex(prev_x, prev_y, ofs_x, ofs_y, 1'b0));
      pending_vertices.push_back(make_vertex(cx, cy, -ofs_x, -ofs_y, 1'b0));
      pending_vertices.push_back(make_vertex(cx, cy, ofs_x, ofs_y, 1'b1));
    end
    prev_x = cx;
    prev_y = cy;
    have_prev = 1'b1;
  endtask

  // Sends one point and waits for its transaction; prediction happens at acceptance.
  // Valid drops only when the sender idles or the test drains.
  task automatic send_point(logic [31:0] x, logic [31:0] y, logic [7:0] width, logic first);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_point_x <= x;
    in_point_y <= y;
    in_line_width <= width;
    in_first_point <= first;
    do @(posedge clk); while (!(in_valid && in_ready));
    predict_vertices(x, y, width, first);
  endtask

  // Waits for every expected vertex, then lets the block settle.
  task automatic drain_outputs();
    in_valid <= 1'b0;
    while (pending_vertices.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  // Register writes happen only while the block is idle.
  task automatic write_center(logic [31:0] cx, logic [31:0] cy);
    cfg_we <= 1'b1;
    cfg_index <= tpqe_pkg::REG_CENTER_X;
    cfg_data <= cx;
    @(posedge clk);
    ctr_x = cx;
    cfg_index <= tpqe_pkg::REG_CENTER_Y;
    cfg_data <= cy;
    @(posedge clk);
    ctr_y = cy;
    cfg_we <= 1'b0;
  endtask

  task automatic test_directed();
    send_point(32'd100, 32'd200, 8'd3, 1'b1);           // thin point
    send_point(32'd0, 32'd0, 8'd0, 1'b0);                // thin, width zero
    send_point(32'd10, 32'd0, 8'd10, 1'b0);              // thick after thin
    send_point(32'd10, 32'd0, 8'd255, 1'b0);             // zero-length segment
    send_point(32'd10, 32'd20, 8'd5, 1'b0);              // smallest thick width
    send_point(32'hFFFFFFF0, 32'hFFFFFFE0, 8'd4, 1'b0);  // largest thin width
    send_point(32'd50, 32'd50, 8'd20, 1'b1);             // new line: stored only
    send_point(32'd53, 32'd54, 8'd20, 1'b0);
    send_point(32'h7FFFFFFF, 32'h80000000, 8'd255, 1'b0);
    send_point(32'h80000000, 32'h7FFFFFFF, 8'd255, 1'b0); // huge segment
    send_point(32'h80000000, 32'h80000000, 8'd128, 1'b0);
    send_point(32'h7FFFFFFF, 32'h7FFFFFFF, 8'd7, 1'b0);
    send_point(32'h12345678, 32'h9ABCDEF0, 8'd200, 1'b1);
    send_point(32'h12345600, 32'h9ABCDEF0, 8'd200, 1'b0); // horizontal
    send_point(32'h12345600, 32'h9ABCDF00, 8'd201, 1'b0); // vertical
    drain_outputs();
  endtask

  task automatic test_center_extremes();
    write_center(32'h7FFFFFFF, 32'h80000000);
    send_point(32'd0, 32'd0, 8'd2, 1'b1);
    send_point(32'd300, 32'hFFFFFF00, 8'd60, 1'b0);
    send_point(32'h80000000, 32'h7FFFFFFF, 8'd1, 1'b0);
    drain_outputs();
    write_center(32'hFFFFFFFF, 32'h0000ABCD);
  endtask

  // Mostly well-formed polylines of small steps, with noise points mixed in.
  task automatic test_random(int n_items);
    logic [31:0] x, y;
    logic [7:0] w;
    bit first;
    int k;
    x = $urandom;
    y = $urandom;
    for (k = 0; k < n_items; k++) begin
      first = ($urandom_range(9) == 0);
      case ($urandom_range(9))
        0: begin
          x = $urandom;
          y = $urandom;
        end
        1: ;  // repeat the point
        default: begin
          x = x + $signed($urandom_range(4000)) - 2000;
          y = y + $signed($urandom_range(4000)) - 2000;
        end
      endcase
      w = ($urandom_range(3) == 0) ? 8'($urandom_range(4)) : 8'($urandom_range(255));
      send_point(x, y, w, first);
    end
    drain_outputs();
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = tpqe_pkg::REG_CENTER_X;
    cfg_data = '0;
    in_valid = 1'b0;
    in_point_x = '0;
    in_point_y = '0;
    in_line_width = '0;
    in_first_point = 1'b0;
    ctr_x = '0;
    ctr_y = '0;
    prev_x = 0;
    prev_y = 0;
    have_prev = 1'b0;
    send_idle_pct = 15;
    recv_idle_pct = 76;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_center_extremes();
    test_random(64);
    send_idle_pct = 76;
    recv_idle_pct = 15;
    write_center(32'h80000000, 32'h7FFFFFFF);
    test_random(64);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_center(32'h00001234, 32'hFFFF8000);
    test_random(64);

    if (!failed)
      $display("** thick_polyline_quad_expander_unit: PASSED **");
    else
      $display("** thick_polyline_quad_expander_unit: FAILED **");
    $finish;
  end

endmodule

`default_nettype wire

/* filelist.f */
rtl/tpqe_pkg.sv
rtl/tpqe_sqdiv.sv
rtl/thick_polyline_quad_expander_unit.sv
verif/thick_polyline_quad_expander_unit_tb.sv
